// File: hdl/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg: shared types and constants of the two-button fan speed control
// Configuration layout, register indexes, button status and result records,
// and the speed to PWM compare conversion.
// ----------------------------------------------------------------------------
package fsc_pkg;

	localparam int TIME_BITS_DEF = 32;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;
	localparam int RUN_W         = 16;
	localparam int SPEED_W       = 7;
	localparam int STEP_W        = 6;
	localparam int PWM_W         = 16;
	localparam int PHASE_W       = 16;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 7'd100;
	localparam logic [SPEED_W:0]   SPEED_TOP   = 8'd100;
	localparam logic [RUN_W-1:0]   RUN_MAX     = 16'hFFFF;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ACTIVE_HIGH   = 3'd0,
		CFG_DEBOUNCE      = 3'd1,
		CFG_STEP_SIZE     = 3'd2,
		CFG_MIN_SPEED     = 3'd3,
		CFG_MAX_SPEED     = 3'd4,
		CFG_HOLD_DELAY    = 3'd5,
		CFG_REPEAT_PERIOD = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic               active_high;
		logic [RUN_W-1:0]   debounce_count;
		logic [STEP_W-1:0]  step_size;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] max_speed;
		logic [15:0]        hold_delay_ms;
		logic [PHASE_W-1:0] repeat_period_ms;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		active_high:      1'b1,
		debounce_count:   16'd0,
		step_size:        6'd5,
		min_speed:        7'd5,
		max_speed:        7'd100,
		hold_delay_ms:    16'd1000,
		repeat_period_ms: 16'd500
	};

	// Per-button debounce outcome of one tick
	typedef struct packed {
		logic on;        // qualified pressed state after this tick
		logic fresh;     // press accepted this tick
		logic released;  // release accepted this tick
	} btn_stat_t;

	// Result of one tick before the PWM conversion
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               down_held;
		logic               up_held;
		logic               changed;
	} result_t;

	// floor(65535 * s / 100) = 655 * s + floor(7 * s / 20); the second term
	// uses the reciprocal 22939 / 2^16, exact for every speed up to 127.
	function automatic logic [PWM_W-1:0] pwm_of(input logic [SPEED_W-1:0] s);
		logic [PWM_W-1:0] base;
		logic [21:0]      frac;
		base = PWM_W'({9'd0, s} * 16'd655);
		frac = {15'd0, s} * 22'd22939;
		return base + PWM_W'(frac[21:16]);
	endfunction

endpackage

// File: hdl/fsc_debounce.sv
// ----------------------------------------------------------------------------
// fsc_debounce: run-count debounce of one button
// Counts press and release runs, qualifies them against the debounce limit
// and keeps the time stamp of the accepted press.
// ----------------------------------------------------------------------------
module fsc_debounce #(
	parameter int TIME_BITS = fsc_pkg::TIME_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      pressed,
	input  logic [fsc_pkg::RUN_W-1:0] debounce_count,
	input  logic [TIME_BITS-1:0]      time_now,
	output fsc_pkg::btn_stat_t        stat,
	output logic [TIME_BITS-1:0]      press_start
);

	logic [fsc_pkg::RUN_W-1:0] press_run_q, release_run_q;
	logic [fsc_pkg::RUN_W-1:0] press_run_n, release_run_n;
	logic                      on_q;
	logic [TIME_BITS-1:0]      press_start_q;

	// Saturating run counts and acceptance
	always_comb begin
		stat = '0;
		if (pressed) begin
			press_run_n   = (press_run_q == fsc_pkg::RUN_MAX) ? press_run_q
			                : press_run_q + 1'b1;
			release_run_n = '0;
			stat.fresh    = (press_run_n >= debounce_count) && !on_q;
		end else begin
			press_run_n   = '0;
			release_run_n = (release_run_q == fsc_pkg::RUN_MAX) ? release_run_q
			                : release_run_q + 1'b1;
			stat.released = (release_run_n >= debounce_count) && on_q;
		end
		stat.on = (on_q || stat.fresh) && !stat.released;
		if (stat.fresh) begin
			press_start = time_now;
		end else if (stat.released) begin
			press_start = '0;
		end else begin
			press_start = press_start_q;
		end
	end

	// Commit on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_run_q   <= '0;
			release_run_q <= '0;
			on_q          <= 1'b0;
			press_start_q <= '0;
		end else if (en) begin
			press_run_q   <= press_run_n;
			release_run_q <= release_run_n;
			on_q          <= stat.on;
			press_start_q <= press_start;
		end
	end

endmodule

// File: hdl/fsc_cfg_regs.sv
// ----------------------------------------------------------------------------
// fsc_cfg_regs: configuration register file
// Write-only registers loaded by index from the configuration port.
// ----------------------------------------------------------------------------
module fsc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output fsc_pkg::cfg_t                  cfg
);

	fsc_pkg::cfg_t cfg_q;

	assign cfg = cfg_q;

	// Decode the index and load the addressed field
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fsc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fsc_pkg::CFG_ACTIVE_HIGH:   cfg_q.active_high      <= cfg_wdata[0];
				fsc_pkg::CFG_DEBOUNCE:      cfg_q.debounce_count   <= cfg_wdata;
				fsc_pkg::CFG_STEP_SIZE:     cfg_q.step_size        <= cfg_wdata[5:0];
				fsc_pkg::CFG_MIN_SPEED:     cfg_q.min_speed        <= cfg_wdata[6:0];
				fsc_pkg::CFG_MAX_SPEED:     cfg_q.max_speed        <= cfg_wdata[6:0];
				fsc_pkg::CFG_HOLD_DELAY:    cfg_q.hold_delay_ms    <= cfg_wdata;
				fsc_pkg::CFG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

endmodule

// File: hdl/fsc_core.sv
// ----------------------------------------------------------------------------
// fsc_core: per-tick speed control logic
// Time base, both debouncers, release stamps, repeat phase and the bounded
// down and up speed steps of one tick.
// ----------------------------------------------------------------------------
module fsc_core #(
	parameter int TIME_BITS = fsc_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             down_level,
	input  logic             up_level,
	input  fsc_pkg::cfg_t    cfg,
	output fsc_pkg::result_t result
);

	logic [TIME_BITS-1:0]        time_q, time_n;
	logic [fsc_pkg::SPEED_W-1:0] speed_q, speed_a, speed_n;
	logic [TIME_BITS-1:0]        rel_stamp_q [2];
	logic [TIME_BITS-1:0]        rel_stamp_n [2];
	logic [TIME_BITS-1:0]        stamp0_a;
	logic [fsc_pkg::PHASE_W-1:0] phase_q, phase_n;
	logic [fsc_pkg::PHASE_W:0]   phase_inc;
	fsc_pkg::btn_stat_t          dn_stat, up_stat;
	logic [TIME_BITS-1:0]        dn_start, up_start;
	logic [TIME_BITS-1:0]        dn_elapsed, up_elapsed;
	logic                        both_off, rel_dn, rel_up, rep_dn, rep_up;
	logic                        do_dn, do_up, dn_ok, up_ok;
	logic [fsc_pkg::SPEED_W:0]   dn_diff, up_sum;
	logic [TIME_BITS-1:0]        hold_ext;

	assign time_n   = time_q + 1'b1;
	assign hold_ext = TIME_BITS'(cfg.hold_delay_ms);

	fsc_debounce #(.TIME_BITS(TIME_BITS)) u_dn (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.pressed        (down_level == cfg.active_high),
		.debounce_count (cfg.debounce_count),
		.time_now       (time_n),
		.stat           (dn_stat),
		.press_start    (dn_start)
	);

	fsc_debounce #(.TIME_BITS(TIME_BITS)) u_up (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.pressed        (up_level == cfg.active_high),
		.debounce_count (cfg.debounce_count),
		.time_now       (time_n),
		.stat           (up_stat),
		.press_start    (up_start)
	);

	// Restart the repeat phase on a fresh press, else wrap at the period
	always_comb begin
		phase_inc = {1'b0, phase_q} + 1'b1;
		if (dn_stat.fresh || up_stat.fresh || phase_inc >= {1'b0, cfg.repeat_period_ms}) begin
			phase_n = '0;
		end else begin
			phase_n = phase_inc[fsc_pkg::PHASE_W-1:0];
		end
	end

	// Pick the steps: release steps with both off, repeat with one held
	always_comb begin
		rel_stamp_n[0] = dn_stat.released ? time_n : rel_stamp_q[0];
		rel_stamp_n[1] = up_stat.released ? time_n : rel_stamp_q[1];
		both_off       = !dn_stat.on && !up_stat.on;
		rel_dn         = both_off && (rel_stamp_n[0] > rel_stamp_n[1]);
		stamp0_a       = rel_dn ? '0 : rel_stamp_n[0];
		rel_up         = both_off && (stamp0_a < rel_stamp_n[1]);
		dn_elapsed     = time_n - dn_start;
		up_elapsed     = time_n - up_start;
		rep_dn         = dn_stat.on && !up_stat.on && (dn_elapsed > hold_ext) && (phase_n == '0);
		rep_up         = !dn_stat.on && up_stat.on && (up_elapsed > hold_ext) && (phase_n == '0);
		do_dn          = rel_dn || rep_dn;
		do_up          = rel_up || rep_up;
	end

	// Bounded down step, then bounded up step on its outcome
	always_comb begin
		dn_diff = {1'b0, speed_q} - {2'b0, cfg.step_size};
		dn_ok   = do_dn && !dn_diff[fsc_pkg::SPEED_W]
		          && (dn_diff[fsc_pkg::SPEED_W-1:0] >= cfg.min_speed);
		speed_a = dn_ok ? dn_diff[fsc_pkg::SPEED_W-1:0] : speed_q;
		up_sum  = {1'b0, speed_a} + {2'b0, cfg.step_size};
		up_ok   = do_up && (up_sum <= {1'b0, cfg.max_speed}) && (up_sum <= fsc_pkg::SPEED_TOP);
		speed_n = up_ok ? up_sum[fsc_pkg::SPEED_W-1:0] : speed_a;

		result.speed     = speed_n;
		result.down_held = dn_stat.on;
		result.up_held   = up_stat.on;
		result.changed   = dn_ok || up_ok;
	end

	// Commit the tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q         <= '0;
			speed_q        <= fsc_pkg::SPEED_RESET;
			rel_stamp_q[0] <= '0;
			rel_stamp_q[1] <= '0;
			phase_q        <= '0;
		end else if (en) begin
			time_q         <= time_n;
			speed_q        <= speed_n;
			rel_stamp_q[0] <= stamp0_a;
			rel_stamp_q[1] <= rel_up ? '0 : rel_stamp_n[1];
			phase_q        <= phase_n;
		end
	end

endmodule

// File: hdl/two_button_fan_speed_control_unit.sv
// ----------------------------------------------------------------------------
// two_button_fan_speed_control_unit: fan speed from two debounced buttons
// Top level with the stream ports, input stage and result register.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick with the down and up button levels;
// each tick yields exactly one result beat with the speed, its PWM compare
// value and the qualified button states. The block takes one beat per clock
// while m_axis_tready does not stall the result register; each accepted beat
// passes through the input register, then the single-pass tick logic into the
// result register, and the rate is set by that tick logic, which finishes a
// whole tick in a single pass. A result waiting on m_axis_tready stops the
// tick in the input stage, and then no further input beat is accepted.
// Configuration writes are expected only while no tick is in flight.
module two_button_fan_speed_control_unit #(
	parameter int TIME_BITS = fsc_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_we,
	input  logic [fsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input ticks
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // [0] down_level, [1] up_level
	// results
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [31:0]                    m_axis_tdata   // [6:0] speed_percent,
	                                                      // [22:7] pwm_compare,
	                                                      // [23] down_held, [24] up_held,
	                                                      // [25] speed_changed
);

	fsc_pkg::cfg_t    cfg;
	fsc_pkg::result_t result_n, result_q;
	logic             valid_s1, down_s1, up_s1;
	logic             out_valid_q;
	logic             advance, in_beat;

	fsc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	fsc_core #(.TIME_BITS(TIME_BITS)) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.down_level (down_s1),
		.up_level   (up_s1),
		.cfg        (cfg),
		.result     (result_n)
	);

	// Move a tick into the result register when that register frees up
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			down_s1 <= s_axis_tdata[0];
			up_s1   <= s_axis_tdata[1];
		end
	end

	// Result register: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'd0, result_q.changed, result_q.up_held, result_q.down_held,
	                        fsc_pkg::pwm_of(result_q.speed), result_q.speed};

endmodule

// File: hdl/fsc_checker.sv
// ----------------------------------------------------------------------------
// fsc_checker: port-level checks of the fan speed control unit
// Watches the result stream and flags results no tick can produce.
// ----------------------------------------------------------------------------
module fsc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// A stalled result beat stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result beat withdrawn while stalled");

	// Speed never leaves its range
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd100)
		else $error("speed above 100 percent");

	// Full speed and only full speed gives the full compare value
	a_pwm_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[6:0] == 7'd100) == (m_axis_tdata[22:7] == 16'hFFFF)))
		else $error("PWM compare disagrees with full speed");

	// No step while both buttons are held
	a_no_step_both: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[25] && m_axis_tdata[23] && m_axis_tdata[24]))
		else $error("speed stepped with both buttons held");

endmodule

bind two_button_fan_speed_control_unit fsc_checker u_fsc_checker (.*);
